/* design/generational_handle_allocator_unit_defines.svh */
// Shared assertion macros
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define GHAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ghau_pkg.sv */
`timescale 1ns / 1ps
package ghau_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CHECK   = 2'd2,
    OP_LOOKUP  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DEAD = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

/* design/ghau_free_stack.sv */
`timescale 1ns / 1ps
module ghau_free_stack
  import ghau_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  stk_ctl_t                     ctl,
  input  logic [$clog2(SLOTS)-1:0]     push_idx,
  output logic [$clog2(SLOTS)-1:0]     top_idx,
  output logic [$clog2(SLOTS+1)-1:0]   depth
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [IW-1:0] mem [SLOTS];
  logic [CW-1:0] depth_next;
  logic [CW-1:0] depth_dec;

  assign depth_dec = depth - CW'(1);

  always_comb begin
    depth_next = depth;
    if (ctl.pop) begin
      depth_next = depth_dec;
    end else if (ctl.push) begin
      depth_next = depth + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[depth[IW-1:0]] <= push_idx;
    end
    if (ctl.pop) begin
      top_idx <= mem[depth_dec[IW-1:0]];
    end
  end

endmodule

/* design/generational_handle_allocator_unit.sv */
`timescale 1ns / 1ps
// Sequence: the accepting edge registers the command and reads the version memory; in
//   EXEC the result is formed, the version memory written and done registered. A create
//   that reuses a freed slot pops the free stack instead and reads its version in POP first.
//   The unit takes no new item while busy, which is high while an item is in flight.
// Reset: synchronous, clears control state and counts; memories are not cleared since
//   the slots-in-use count gates every use of read data. Ready the cycle after reset. No output stall.
`include "generational_handle_allocator_unit_defines.svh"
module generational_handle_allocator_unit
  import ghau_pkg::*;
#(
  parameter int SLOTS        = 1024,
  parameter int VERSION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [15:0] slot_index,
  input  logic [31:0] slot_version,
  output logic        done,
  output logic [1:0]  status,
  output logic        alive,
  output logic [9:0]  result_index,
  output logic [31:0] result_version
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int VB = VERSION_BITS;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  state_t state, state_next;

  op_t            op_q;
  logic [31:0]    ver_q;
  logic [IW-1:0]  slot_q;
  logic [IW-1:0]  slot_next;
  logic           in_range_q;
  logic           crt_pop_q;
  logic           crt_fresh_q;
  logic [CW-1:0]  used;
  logic [CW-1:0]  used_next;

  logic [VB:0]    vmem [SLOTS];
  logic [VB:0]    mem_q;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic           wr_en;
  logic [VB:0]    wr_data;

  stk_ctl_t       stk_ctl;
  logic [IW-1:0]  stk_top;
  logic [CW-1:0]  stk_depth;

  logic           accept;
  logic           entry_free;
  logic [VB-1:0]  entry_ver;
  logic           live;
  logic           handle_ok;

  logic [1:0]     status_next;
  logic           alive_next;
  logic [9:0]     result_index_next;
  logic [31:0]    result_version_next;

  ghau_free_stack #(
    .SLOTS(SLOTS)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .ctl     (stk_ctl),
    .push_idx(slot_q),
    .top_idx (stk_top),
    .depth   (stk_depth)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign entry_free = mem_q[VB];
  assign entry_ver  = mem_q[VB-1:0];
  assign live       = in_range_q && !entry_free;
  assign handle_ok  = live && (32'(entry_ver) == ver_q);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(op) == OP_CREATE && stk_depth != '0) begin
            state_next = S_POP;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_POP:   state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en               = 1'b0;
    rd_addr             = slot_index[IW-1:0];
    wr_en               = 1'b0;
    wr_data             = '0;
    stk_ctl             = '0;
    slot_next           = slot_q;
    used_next           = used;
    status_next         = ST_OK;
    alive_next          = 1'b0;
    result_index_next   = '0;
    result_version_next = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (op_t'(op) == OP_CREATE) begin
            slot_next   = used[IW-1:0];
            stk_ctl.pop = (stk_depth != '0);
          end else begin
            slot_next = slot_index[IW-1:0];
          end
        end
      end
      S_POP: begin
        rd_en     = 1'b1;
        rd_addr   = stk_top;
        slot_next = stk_top;
      end
      S_EXEC: begin
        case (op_q)
          OP_CREATE: begin
            if (crt_pop_q) begin
              wr_en               = 1'b1;
              wr_data             = {1'b0, entry_ver};
              alive_next          = 1'b1;
              result_index_next   = 10'(slot_q);
              result_version_next = 32'(entry_ver);
            end else if (crt_fresh_q) begin
              wr_en             = 1'b1;
              wr_data           = '0;
              used_next         = used + CW'(1);
              alive_next        = 1'b1;
              result_index_next = 10'(slot_q);
            end else begin
              status_next = ST_FULL;
            end
          end
          OP_DESTROY: begin
            if (handle_ok && stk_depth != SLOTS_C) begin
              wr_en        = 1'b1;
              wr_data      = {1'b1, VB'(entry_ver + 1'b1)};
              stk_ctl.push = 1'b1;
            end else begin
              status_next = ST_DEAD;
            end
          end
          OP_CHECK: begin
            alive_next = handle_ok;
          end
          default: begin
            if (live) begin
              alive_next          = 1'b1;
              result_index_next   = 10'(slot_q);
              result_version_next = 32'(entry_ver);
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    slot_q <= slot_next;
    if (accept) begin
      op_q        <= op_t'(op);
      ver_q       <= slot_version;
      in_range_q  <= ({1'b0, slot_index} < 17'(used));
      crt_pop_q   <= (stk_depth != '0);
      crt_fresh_q <= (used < SLOTS_C);
    end
    if (state == S_EXEC) begin
      status         <= status_next;
      alive          <= alive_next;
      result_index   <= result_index_next;
      result_version <= result_version_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[slot_q] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= vmem[rd_addr];
    end
  end

  `GHAU_ASSERT_NEXT(a_exec_gives_done, state == S_EXEC, done && !busy, "exec without result")
  `GHAU_ASSERT_NEXT(a_accept_sets_busy, accept, busy, "transfer did not start work")
  `GHAU_ASSERT_NOW(a_free_within_used, state == S_IDLE, stk_depth <= used, "free count over used")
  `GHAU_ASSERT_NOW(a_full_not_alive, done && status == ST_FULL, !alive, "full create alive")
  `GHAU_ASSERT_NOW(a_pop_only_create, stk_ctl.pop, op_t'(op) == OP_CREATE && accept, "stray pop")

endmodule

/* tb/tb_generational_handle_allocator_unit.sv */
`timescale 1ns / 1ps
module tb_generational_handle_allocator_unit;
  import ghau_pkg::*;

  localparam int SLOTS = 1024;
  localparam int RAND_ITEMS = 1625;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  st;
    logic        live;
    logic [9:0]  idx;
    logic [31:0] ver;
  } outcome_t;

  typedef struct {
    op_t         op;
    logic [15:0] idx;
    logic [31:0] ver;
    bit          typed;
    outcome_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = OP_CREATE;
  logic [15:0] slot_index = '0;
  logic [31:0] slot_version = '0;
  logic        done;
  logic [1:0]  status;
  logic        alive;
  logic [9:0]  result_index;
  logic [31:0] result_version;

  // allocator state as seen by the predictor
  bit [31:0] ver_tab [SLOTS];
  bit [9:0]  free_stk [SLOTS];
  bit        free_flag [SLOTS];
  int        free_cnt = 0;
  int        used_cnt = 0;

  outcome_t  pending_results [$];
  stim_row_t dir_rows [$];
  int        error_count = 0;
  int        full_hits = 0;
  int        cycles = 0;
  bit        bursty = 1'b0;

  generational_handle_allocator_unit #(
    .SLOTS(SLOTS),
    .VERSION_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .slot_index(slot_index),
    .slot_version(slot_version),
    .done(done),
    .status(status),
    .alive(alive),
    .result_index(result_index),
    .result_version(result_version)
  );

  always #5 clk = ~clk;

  function automatic bit slot_is_live(logic [15:0] i);
    if (int'(i) >= used_cnt) return 1'b0;
    return !free_flag[i];
  endfunction

  function automatic bit handle_is_live(logic [15:0] i, logic [31:0] v);
    if (!slot_is_live(i)) return 1'b0;
    return ver_tab[i] == v;
  endfunction

  function automatic outcome_t predict_handle_result(op_t o, logic [15:0] i, logic [31:0] v);
    outcome_t r;
    int s;
    r = '0;
    case (o)
      OP_CREATE: begin
        if (free_cnt > 0) begin
          free_cnt--;
          s = int'(free_stk[free_cnt]);
          free_flag[s] = 1'b0;
          r.live = 1'b1;
          r.idx = s[9:0];
          r.ver = ver_tab[s];
        end else if (used_cnt < SLOTS) begin
          s = used_cnt;
          ver_tab[s] = '0;
          free_flag[s] = 1'b0;
          used_cnt++;
          r.live = 1'b1;
          r.idx = s[9:0];
        end else begin
          r.st = ST_FULL;
        end
      end
      OP_DESTROY: begin
        if (handle_is_live(i, v) && free_cnt < SLOTS) begin
          ver_tab[i] = ver_tab[i] + 32'd1;
          free_flag[i] = 1'b1;
          free_stk[free_cnt] = i[9:0];
          free_cnt++;
        end else begin
          r.st = ST_DEAD;
        end
      end
      OP_CHECK: r.live = handle_is_live(i, v);
      default: begin
        if (slot_is_live(i)) begin
          r.live = 1'b1;
          r.idx = i[9:0];
          r.ver = ver_tab[i];
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int w;
    if (bursty) return 0;
    w = $urandom_range(0, 99);
    if (w < 60) return 0;
    if (w < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic add_row(op_t o, logic [15:0] i, logic [31:0] v, bit typed,
                         logic [1:0] st, logic live, logic [9:0] ri, logic [31:0] rv);
    stim_row_t row;
    row.op = o;
    row.idx = i;
    row.ver = v;
    row.typed = typed;
    row.want = '{st: st, live: live, idx: ri, ver: rv};
    dir_rows = {dir_rows, row};
  endtask

  // one command transfer; the expectation is booked at the accepting edge
  task automatic send_item(op_t o, logic [15:0] i, logic [31:0] v, bit typed, outcome_t want);
    outcome_t pred;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    slot_index <= i;
    slot_version <= v;
    do @(posedge clk); while (busy);
    pred = predict_handle_result(o, i, v);
    if (pred.st == ST_FULL) full_hits++;
    if (typed) pred = want;
    pending_results = {pending_results, pred};
  endtask

  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d alive %0d index %0d version %0d",
               status, alive, result_index, result_version);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status);
          error_count++;
        end
        if (alive !== exp_r.live) begin
          $error("alive: expected %0d, got %0d", exp_r.live, alive);
          error_count++;
        end
        if (result_index !== exp_r.idx) begin
          $error("result_index: expected %0d, got %0d", exp_r.idx, result_index);
          error_count++;
        end
        if (result_version !== exp_r.ver) begin
          $error("result_version: expected %0d, got %0d", exp_r.ver, result_version);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** generational_handle_allocator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int k;
    int w;
    int n;
    bit filling;
    op_t o;
    logic [15:0] i;
    logic [31:0] v;

    // after reset, extremes, reuse order and dead handles
    add_row(OP_LOOKUP,  16'd0,    32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_CHECK,   16'd0,    32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_DESTROY, 16'd0,    32'd0,         1'b1, ST_DEAD, 1'b0, 10'd0, 32'd0);
    add_row(OP_CREATE,  16'd0,    32'd0,         1'b1, ST_OK,   1'b1, 10'd0, 32'd0);
    add_row(OP_CREATE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,   1'b1, 10'd1, 32'd0);
    add_row(OP_LOOKUP,  16'd1,    32'd0,         1'b1, ST_OK,   1'b1, 10'd1, 32'd0);
    add_row(OP_CHECK,   16'd1,    32'd0,         1'b1, ST_OK,   1'b1, 10'd0, 32'd0);
    add_row(OP_CHECK,   16'd1,    32'd1,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_DESTROY, 16'd1,    32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    // freed slot is not live even with its current version
    add_row(OP_CHECK,   16'd1,    32'd1,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_LOOKUP,  16'd1,    32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_DESTROY, 16'd1,    32'd1,         1'b1, ST_DEAD, 1'b0, 10'd0, 32'd0);
    add_row(OP_CREATE,  16'd0,    32'd0,         1'b1, ST_OK,   1'b1, 10'd1, 32'd1);
    add_row(OP_LOOKUP,  16'hFFFF, 32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_CHECK,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_DESTROY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_DEAD, 1'b0, 10'd0, 32'd0);
    // index aliasing slot 0 in the low bits
    add_row(OP_LOOKUP,  16'h0400, 32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_CHECK,   16'd2,    32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_DESTROY, 16'd0,    32'd0,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_DESTROY, 16'd1,    32'd1,         1'b1, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_CREATE,  16'd0,    32'd0,         1'b1, ST_OK,   1'b1, 10'd1, 32'd2);
    add_row(OP_CREATE,  16'd0,    32'd0,         1'b1, ST_OK,   1'b1, 10'd0, 32'd1);
    add_row(OP_CREATE,  16'hAAAA, 32'h5555_5555, 1'b1, ST_OK,   1'b1, 10'd2, 32'd0);
    add_row(OP_LOOKUP,  16'd0,    32'hFFFF_FFFF, 1'b0, ST_OK,   1'b0, 10'd0, 32'd0);
    add_row(OP_CHECK,   16'd0,    32'hFFFF_FFFF, 1'b0, ST_OK,   1'b0, 10'd0, 32'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r])
      send_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].ver,
                dir_rows[r].typed, dir_rows[r].want);

    // fill until full, then churn with a mix of all commands
    filling = 1'b1;
    k = 0;
    while (k < RAND_ITEMS || filling) begin
      w = $urandom_range(0, 99);
      if (filling)
        o = (w < 88) ? OP_CREATE : (w < 94) ? OP_DESTROY : (w < 97) ? OP_CHECK : OP_LOOKUP;
      else
        o = (w < 30) ? OP_CREATE : (w < 60) ? OP_DESTROY : (w < 80) ? OP_CHECK : OP_LOOKUP;
      n = $urandom_range(0, 99);
      i = 16'($urandom);
      v = $urandom;
      if (o != OP_CREATE && used_cnt > 0 && n >= 12) begin
        i = 16'($urandom_range(0, used_cnt - 1));
        v = ver_tab[i];
        if (n < 22) v = v ^ (32'd1 << $urandom_range(0, 31));
        else if (n < 28) v = v - 32'd1;
      end
      send_item(o, i, v, 1'b0, '0);
      k++;
      if (filling && used_cnt == SLOTS && free_cnt == 0 && full_hits >= 6) filling = 1'b0;
      if (k % 64 == 0) bursty = ($urandom_range(0, 2) == 0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("** generational_handle_allocator_unit: PASSED **");
    else
      $display("** generational_handle_allocator_unit: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/ghau_pkg.sv
design/ghau_free_stack.sv
design/generational_handle_allocator_unit.sv
tb/tb_generational_handle_allocator_unit.sv
